>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the state packet acceptance filter.
// No dependencies; a build that defines SYNTH gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define SAPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define SAPF_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SAPF_ASSERT(label, clk, rst, prop, msg)

`define SAPF_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> src/sapf_pkg.sv
// Package for the state packet acceptance filter: status codes, register
// indexes, field widths and fixed constants. No dependencies.
`timescale 1ns / 1ps

package sapf_pkg;

   localparam int STATUS_W   = 4;
   localparam int DEV_IDX_W  = 5;
   localparam int LEN_W      = 8;
   localparam int MAGIC_W    = 16;
   localparam int VER_W      = 8;
   localparam int NEWEST_W   = 2;
   localparam int SEQ_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   // Number of device slots that the device index can address.
   localparam int DEV_SLOTS = 1 << DEV_IDX_W;

   // A sequence number equal to the stored one, or fewer than this many below it, is a replay.
   localparam int STALE_WINDOW = 5;

   // Value of every sequence slot after reset.
   localparam logic [SEQ_W-1:0] SEQ_RESET = 16'hFFFF;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK            = 4'd0;
   localparam status_type ST_UNKNOWN       = 4'd1;
   localparam status_type ST_SHORT_HEADER  = 4'd2;
   localparam status_type ST_BAD_MAGIC     = 4'd3;
   localparam status_type ST_TOO_OLD       = 4'd4;
   localparam status_type ST_BAD_KNOWN_LEN = 4'd5;
   localparam status_type ST_TRUNC_KNOWN   = 4'd6;
   localparam status_type ST_FUTURE_SHORT  = 4'd7;
   localparam status_type ST_FUTURE_TRUNC  = 4'd8;
   localparam status_type ST_STALE         = 4'd9;
   localparam status_type ST_NOT_MANAGED   = 4'd10;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_MAGIC     = 3'd0;
   localparam csr_idx_type REG_OLDEST    = 3'd1;
   localparam csr_idx_type REG_NEWEST    = 3'd2;
   localparam csr_idx_type REG_LENGTH_V0 = 3'd3;
   localparam csr_idx_type REG_LENGTH_V1 = 3'd4;
   localparam csr_idx_type REG_LENGTH_V2 = 3'd5;
   localparam csr_idx_type REG_LENGTH_V3 = 3'd6;

endpackage

>>> src/state_packet_acceptance_filter.sv
// State packet acceptance filter: top level with header checks, replay
// check and per-device sequence store. Depends on sapf_pkg and on
// assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  Channel   Direction  Handshake                       Beat
//  req_*     in         req_valid / req_stall           one decoded packet header
//  rsp_*     out        rsp_valid / rsp_stall           status and version flags
//  APB       in/out     psel penable pwrite, pready=1   one register write or read
//
// A header is checked while it sits in the input register and its result beat is
// offered once it has moved into the result register; while req_stall is low, a
// new header can be taken every cycle, as the sequence store needs only one read-modify-write.
// Reset is synchronous and active high; it loads the register defaults and
// sets every sequence slot to 65535 in the same cycle.
// req_stall rises only when both registers are full and rsp_stall is high.

module state_packet_acceptance_filter
   import sapf_pkg::*;
#(
   parameter int MAX_DEVICES = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_source_known,
   input  logic [DEV_IDX_W-1:0]  req_device_index,
   input  logic [LEN_W-1:0]      req_received_length,
   input  logic [MAGIC_W-1:0]    req_packet_magic_field,
   input  logic [VER_W-1:0]      req_packet_version,
   input  logic [LEN_W-1:0]      req_declared_length,
   input  logic [SEQ_W-1:0]      req_seq_number,
   input  logic                  req_managed_flag,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_has_v2_part,
   output logic                  rsp_has_v3_part,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Only device indexes below both MAX_DEVICES and the index range ever
   // reach the store, so it never needs more slots than that.
   localparam int DEPTH = (MAX_DEVICES < DEV_SLOTS) ? MAX_DEVICES : DEV_SLOTS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ------------------------------------------------------------------
   // Configuration registers. The user changes them only while the block is idle; the block does not enforce it.
   // ------------------------------------------------------------------
   logic [MAGIC_W-1:0]  magic_ff;
   logic [VER_W-1:0]    oldest_ff;
   logic [NEWEST_W-1:0] newest_ff;
   logic [LEN_W-1:0]    len_ff [4];

   logic        csr_write;
   csr_idx_type csr_idx;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff  <= '0;
         oldest_ff <= 8'd1;
         newest_ff <= 2'd3;
         for (int i = 0; i < 4; i++) begin
            len_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_MAGIC:     magic_ff  <= pwdata[MAGIC_W-1:0];
            REG_OLDEST:    oldest_ff <= pwdata[VER_W-1:0];
            REG_NEWEST:    newest_ff <= pwdata[NEWEST_W-1:0];
            REG_LENGTH_V0: len_ff[0] <= pwdata[LEN_W-1:0];
            REG_LENGTH_V1: len_ff[1] <= pwdata[LEN_W-1:0];
            REG_LENGTH_V2: len_ff[2] <= pwdata[LEN_W-1:0];
            REG_LENGTH_V3: len_ff[3] <= pwdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Reads see the register values zero-extended to the bus width.
   always_comb begin
      unique case (csr_idx)
         REG_MAGIC:     prdata = CSR_DATA_W'(magic_ff);
         REG_OLDEST:    prdata = CSR_DATA_W'(oldest_ff);
         REG_NEWEST:    prdata = CSR_DATA_W'(newest_ff);
         REG_LENGTH_V0: prdata = CSR_DATA_W'(len_ff[0]);
         REG_LENGTH_V1: prdata = CSR_DATA_W'(len_ff[1]);
         REG_LENGTH_V2: prdata = CSR_DATA_W'(len_ff[2]);
         REG_LENGTH_V3: prdata = CSR_DATA_W'(len_ff[3]);
         default:       prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Input register. It is the first of the two stages; the result
   // register behind it is the second, so a waiting result blocks the
   // next header only once this register holds a header as well.
   // ------------------------------------------------------------------
   logic                 in_valid_ff, in_valid_in;
   logic                 in_known_ff;
   logic [DEV_IDX_W-1:0] in_dev_ff;
   logic [LEN_W-1:0]     in_rlen_ff;
   logic [MAGIC_W-1:0]   in_magic_ff;
   logic [VER_W-1:0]     in_ver_ff;
   logic [LEN_W-1:0]     in_dlen_ff;
   logic [SEQ_W-1:0]     in_seq_ff;
   logic                 in_managed_ff;

   logic req_accept;
   logic advance;

   // The checked header moves into the result register when that register
   // is empty or its beat is being taken this cycle.
   assign advance    = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_known_ff   <= req_source_known;
         in_dev_ff     <= req_device_index;
         in_rlen_ff    <= req_received_length;
         in_magic_ff   <= req_packet_magic_field;
         in_ver_ff     <= req_packet_version;
         in_dlen_ff    <= req_declared_length;
         in_seq_ff     <= req_seq_number;
         in_managed_ff <= req_managed_flag;
      end
   end

   // ------------------------------------------------------------------
   // Sequence store: one 16-bit slot per device, read and written at the
   // same index in the check cycle, so the next header already sees the
   // updated number and no forwarding is needed.
   // ------------------------------------------------------------------
   logic [SEQ_W-1:0] seq_ff [DEPTH];
   logic [IDX_W-1:0] idx;
   logic             seq_update;

   assign idx = in_dev_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            seq_ff[i] <= SEQ_RESET;
         end
      end else if (seq_update) begin
         seq_ff[idx] <= in_seq_ff;
      end
   end

   // ------------------------------------------------------------------
   // Checks. The first failing check decides the status. A version up to
   // the newest known one must match its table length and arrive in full;
   // a newer version must declare at least the newest known length and
   // arrive at exactly that length.
   // ------------------------------------------------------------------
   logic             dev_ok;
   logic             ver_known;
   logic [LEN_W-1:0] known_len;
   logic [LEN_W-1:0] newest_len;
   logic [SEQ_W-1:0] last_seq;
   logic [SEQ_W-1:0] seq_gap;
   logic             stale;
   status_type       hdr_status;
   status_type       status;

   always_comb begin
      dev_ok     = in_known_ff && (32'(in_dev_ff) < MAX_DEVICES);
      ver_known  = in_ver_ff <= VER_W'(newest_ff);
      known_len  = len_ff[in_ver_ff[NEWEST_W-1:0]];
      newest_len = len_ff[newest_ff];

      priority if (!dev_ok) begin
         hdr_status = ST_UNKNOWN;
      end else if (in_rlen_ff < len_ff[0]) begin
         hdr_status = ST_SHORT_HEADER;
      end else if (in_magic_ff != magic_ff) begin
         hdr_status = ST_BAD_MAGIC;
      end else if (in_ver_ff < oldest_ff) begin
         hdr_status = ST_TOO_OLD;
      end else if (ver_known && (in_dlen_ff != known_len)) begin
         hdr_status = ST_BAD_KNOWN_LEN;
      end else if (ver_known && (in_rlen_ff != in_dlen_ff)) begin
         hdr_status = ST_TRUNC_KNOWN;
      end else if (!ver_known && (in_dlen_ff < newest_len)) begin
         hdr_status = ST_FUTURE_SHORT;
      end else if (!ver_known && (in_rlen_ff != newest_len)) begin
         hdr_status = ST_FUTURE_TRUNC;
      end else begin
         hdr_status = ST_OK;
      end
   end

   // A number is a replay when it is not above the stored one and lies
   // within the stale window below it; there is no wrap-around handling.
   always_comb begin
      last_seq = seq_ff[idx];
      seq_gap  = last_seq - in_seq_ff;
      stale    = (in_seq_ff <= last_seq) && (32'(seq_gap) < STALE_WINDOW);

      priority if (hdr_status != ST_OK) begin
         status = hdr_status;
      end else if (stale) begin
         status = ST_STALE;
      end else if (!in_managed_ff) begin
         status = ST_NOT_MANAGED;
      end else begin
         status = ST_OK;
      end
   end

   // The number is recorded even when the managed check fails afterwards.
   assign seq_update = advance && (hdr_status == ST_OK) && !stale;

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic       rsp_v2_ff;
   logic       rsp_v3_ff;

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status;
         rsp_v2_ff     <= (status == ST_OK) && (in_ver_ff >= 8'd2);
         rsp_v3_ff     <= (status == ST_OK) && (in_ver_ff >= 8'd3);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_has_v2_part = rsp_v2_ff;
   assign rsp_has_v3_part = rsp_v3_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // A store write always produces an accepted or not-managed result.
   `SAPF_ASSERT(a_update_status, clock, reset, seq_update |=> (rsp_valid && ((rsp_status == ST_OK) || (rsp_status == ST_NOT_MANAGED))), "sequence store written for a rejected header")

   // After a store write the slot holds the number just checked.
   `SAPF_ASSERT(a_update_value, clock, reset, seq_update |=> (seq_ff[$past(idx)] == $past(in_seq_ff)), "sequence slot does not hold the recorded number")

   // The input side stalls only behind a full, stalled result register.
   `SAPF_ASSERT(a_stall_cause, clock, reset, req_stall |-> (in_valid_ff && rsp_valid && rsp_stall), "input stalled without a blocked result")

   // The version three flag implies the version two flag.
   `SAPF_ASSERT_NEVER(a_flag_order, clock, reset, rsp_valid && rsp_has_v3_part && !rsp_has_v2_part, "v3 part flagged without v2 part")

endmodule

>>> dv/state_packet_acceptance_filter_test.sv
// Self-checking testbench for the state packet acceptance filter: directed and random
// packet headers under random idling on both channels, checked against a local predictor.
// Depends on sapf_pkg and on the RTL of state_packet_acceptance_filter.
`timescale 1ns / 1ps

module state_packet_acceptance_filter_test;
   import sapf_pkg::*;

   // One decoded packet header, as it is presented on the req_ channel.
   typedef struct packed {
      logic                 known;
      logic [DEV_IDX_W-1:0] dev;
      logic [LEN_W-1:0]     rlen;
      logic [MAGIC_W-1:0]   magic;
      logic [VER_W-1:0]     ver;
      logic [LEN_W-1:0]     dlen;
      logic [SEQ_W-1:0]     seq;
      logic                 managed;
   } header_t;

   // The filter's decision for one header, as it comes back on the rsp_ channel.
   typedef struct packed {
      status_type status;
      logic       v2;
      logic       v3;
   } verdict_t;

   // Every input starts at a known value; after time zero all but the clock only
   // change by nonblocking assignments right after a rising edge.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_source_known = 1'b0;
   logic [DEV_IDX_W-1:0]  req_device_index = '0;
   logic [LEN_W-1:0]      req_received_length = '0;
   logic [MAGIC_W-1:0]    req_packet_magic_field = '0;
   logic [VER_W-1:0]      req_packet_version = '0;
   logic [LEN_W-1:0]      req_declared_length = '0;
   logic [SEQ_W-1:0]      req_seq_number = '0;
   logic                  req_managed_flag = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_has_v2_part;
   logic                  rsp_has_v3_part;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   state_packet_acceptance_filter dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_source_known       (req_source_known),
      .req_device_index       (req_device_index),
      .req_received_length    (req_received_length),
      .req_packet_magic_field (req_packet_magic_field),
      .req_packet_version     (req_packet_version),
      .req_declared_length    (req_declared_length),
      .req_seq_number         (req_seq_number),
      .req_managed_flag       (req_managed_flag),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_has_v2_part        (rsp_has_v2_part),
      .rsp_has_v3_part        (rsp_has_v3_part),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The predictor's copy of the registers, at their reset values.
   logic [MAGIC_W-1:0]  cfg_magic = '0;
   logic [VER_W-1:0]    cfg_oldest = 8'd1;
   logic [NEWEST_W-1:0] cfg_newest = 2'd3;
   logic [LEN_W-1:0]    len_tab [4] = '{default: '0};

   // The predictor's copy of the per-device sequence store.
   logic [SEQ_W-1:0]    seq_store [DEV_SLOTS] = '{default: SEQ_RESET};

   // Verdicts of accepted headers whose result beat has not come back yet.
   verdict_t pending_verdicts [$];

   int mismatch_count = 0;

   // Counters that stretch runs of back-to-back beats on each side.
   int send_calm = 0;
   int take_calm = 0;

   task automatic flag_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Cycles to idle before the next beat: mostly a random draw, but now and then
   // a stretch of beats with no idling at all.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0)
         calm = $urandom_range(8, 24);
      return $urandom_range(0, 11);
   endfunction

   // Bits that each register actually holds.
   function automatic logic [CSR_DATA_W-1:0] reg_mask(input csr_idx_type idx);
      case (idx)
         REG_MAGIC:  return 32'h0000_FFFF;
         REG_NEWEST: return 32'h0000_0003;
         default:    return 32'h0000_00FF;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(input csr_idx_type idx);
      case (idx)
         REG_MAGIC:     return CSR_DATA_W'(cfg_magic);
         REG_OLDEST:    return CSR_DATA_W'(cfg_oldest);
         REG_NEWEST:    return CSR_DATA_W'(cfg_newest);
         REG_LENGTH_V0: return CSR_DATA_W'(len_tab[0]);
         REG_LENGTH_V1: return CSR_DATA_W'(len_tab[1]);
         REG_LENGTH_V2: return CSR_DATA_W'(len_tab[2]);
         REG_LENGTH_V3: return CSR_DATA_W'(len_tab[3]);
         default:       return '0;
      endcase
   endfunction

   function automatic void apply_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] raw);
      logic [CSR_DATA_W-1:0] kept;
      kept = raw & reg_mask(idx);
      case (idx)
         REG_MAGIC:     cfg_magic = kept[MAGIC_W-1:0];
         REG_OLDEST:    cfg_oldest = kept[VER_W-1:0];
         REG_NEWEST:    cfg_newest = kept[NEWEST_W-1:0];
         REG_LENGTH_V0: len_tab[0] = kept[LEN_W-1:0];
         REG_LENGTH_V1: len_tab[1] = kept[LEN_W-1:0];
         REG_LENGTH_V2: len_tab[2] = kept[LEN_W-1:0];
         REG_LENGTH_V3: len_tab[3] = kept[LEN_W-1:0];
         default:       ;
      endcase
   endfunction

   // Works out the verdict for one accepted header and updates the sequence
   // store the way the block must: only a header that passes every header
   // check and is not a replay records its number, managed or not.
   function automatic verdict_t judge_header(input header_t h);
      verdict_t         v;
      logic [LEN_W-1:0] top_len;
      logic [SEQ_W-1:0] last;
      v.status = ST_OK;
      if (!h.known || int'(h.dev) >= DEV_SLOTS)
         v.status = ST_UNKNOWN;
      else if (h.rlen < len_tab[0])
         v.status = ST_SHORT_HEADER;
      else if (h.magic != cfg_magic)
         v.status = ST_BAD_MAGIC;
      else if (h.ver < cfg_oldest)
         v.status = ST_TOO_OLD;
      else if (h.ver <= cfg_newest) begin
         if (h.dlen != len_tab[h.ver[1:0]])
            v.status = ST_BAD_KNOWN_LEN;
         else if (h.rlen != h.dlen)
            v.status = ST_TRUNC_KNOWN;
      end else begin
         top_len = len_tab[cfg_newest];
         if (h.dlen < top_len)
            v.status = ST_FUTURE_SHORT;
         else if (h.rlen != top_len)
            v.status = ST_FUTURE_TRUNC;
      end
      if (v.status == ST_OK) begin
         last = seq_store[h.dev];
         // Plain unsigned compare: a number just below the stored one is a
         // replay, and there is no wrap-around handling.
         if (h.seq <= last && int'(last - h.seq) < STALE_WINDOW)
            v.status = ST_STALE;
         else begin
            seq_store[h.dev] = h.seq;
            if (!h.managed)
               v.status = ST_NOT_MANAGED;
         end
      end
      v.v2 = (v.status == ST_OK) && (h.ver >= 2);
      v.v3 = (v.status == ST_OK) && (h.ver >= 3);
      return v;
   endfunction

   function automatic header_t pack_header(input logic known, input int dev, input int rlen,
                                           input int magic, input int ver, input int dlen,
                                           input int seq, input logic managed);
      header_t h;
      h.known = known;
      h.dev = DEV_IDX_W'(dev);
      h.rlen = LEN_W'(rlen);
      h.magic = MAGIC_W'(magic);
      h.ver = VER_W'(ver);
      h.dlen = LEN_W'(dlen);
      h.seq = SEQ_W'(seq);
      h.managed = managed;
      return h;
   endfunction

   // Builds a random header. Most are well formed for the current settings,
   // so that they reach the sequence store; the sequence numbers crowd around
   // the replay window. The rest are pure noise or carry one broken field.
   function automatic header_t craft_header();
      header_t          h;
      int               pick;
      int               lo;
      logic [SEQ_W-1:0] last;
      h = header_t'({$urandom, $urandom, $urandom});
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         h.known = 1'b1;
         h.dev = DEV_IDX_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                        : $urandom_range(0, 31));
         h.magic = cfg_magic;
         h.managed = ($urandom_range(0, 9) != 0);
         if (cfg_oldest <= cfg_newest && $urandom_range(0, 1) != 0) begin
            h.ver = VER_W'($urandom_range(cfg_oldest, cfg_newest));
            h.dlen = len_tab[h.ver[1:0]];
            h.rlen = h.dlen;
         end else begin
            lo = (int'(cfg_oldest) > int'(cfg_newest) + 1) ? cfg_oldest : cfg_newest + 1;
            h.ver = VER_W'($urandom_range(lo, 255));
            h.rlen = len_tab[cfg_newest];
            h.dlen = LEN_W'($urandom_range(h.rlen, 255));
         end
         last = seq_store[h.dev];
         case ($urandom_range(0, 3))
            0, 1:    h.seq = SEQ_W'(last + $urandom_range(1, 50));
            2:       h.seq = SEQ_W'(last - $urandom_range(0, STALE_WINDOW));
            default: h.seq = SEQ_W'($urandom);
         endcase
         if (pick == 7) begin
            case ($urandom_range(0, 5))
               0:       h.known = 1'b0;
               1:       h.rlen = LEN_W'($urandom);
               2:       h.magic = MAGIC_W'($urandom);
               3:       h.ver = VER_W'($urandom);
               4:       h.dlen = LEN_W'($urandom);
               default: h.managed = 1'b0;
            endcase
         end
      end
      return h;
   endfunction

   // One register access: a setup cycle, an access cycle that completes when
   // pready is seen high, then an idle cycle so that psel never drops and
   // rises again within the same time step.
   task automatic apb_cycle(input logic wr, input csr_idx_type idx,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input csr_idx_type idx);
      logic [CSR_DATA_W-1:0] got;
      apb_cycle(1'b0, idx, '0, got);
      if (got !== reg_value(idx))
         flag_mismatch($sformatf("register %0d reads %0h, want %0h", idx, got,
                                 reg_value(idx)));
   endtask

   // Writes a register, optionally with junk above the bits it holds, and
   // reads it back.
   task automatic write_reg(input csr_idx_type idx, input int value, input bit noisy);
      logic [CSR_DATA_W-1:0] raw;
      logic [CSR_DATA_W-1:0] unused;
      raw = value;
      if (noisy)
         raw = (raw & reg_mask(idx)) | ($urandom & ~reg_mask(idx));
      apb_cycle(1'b1, idx, raw, unused);
      apply_reg(idx, raw);
      check_reg(idx);
   endtask

   // Holds off new headers until every accepted one has produced its result.
   // Every header yields exactly one result, so an empty queue means idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_config(input int magic, input int oldest, input int newest,
                             input int l0, input int l1, input int l2, input int l3,
                             input bit noisy);
      drain_results();
      write_reg(REG_MAGIC, magic, noisy);
      write_reg(REG_OLDEST, oldest, noisy);
      write_reg(REG_NEWEST, newest, noisy);
      write_reg(REG_LENGTH_V0, l0, noisy);
      write_reg(REG_LENGTH_V1, l1, noisy);
      write_reg(REG_LENGTH_V2, l2, noisy);
      write_reg(REG_LENGTH_V3, l3, noisy);
   endtask

   // Sends one header beat after a random gap and predicts its verdict at the
   // edge where it is taken. The valid stays high on exit, so a following
   // beat with no gap goes out on the very next cycle.
   task automatic send_header(input header_t h);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_known <= h.known;
      req_device_index <= h.dev;
      req_received_length <= h.rlen;
      req_packet_magic_field <= h.magic;
      req_packet_version <= h.ver;
      req_declared_length <= h.dlen;
      req_seq_number <= h.seq;
      req_managed_flag <= h.managed;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(judge_header(h));
   endtask

   task automatic send_random(input int count);
      repeat (count) send_header(craft_header());
   endtask

   // The receiver stalls for a random number of cycles before each result
   // beat, stalls sometimes fall while no result is pending at all, and now
   // and then it takes a run of beats without stalling.
   initial begin : result_taker
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = draw_wait(take_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Every result beat taken is compared with the oldest pending verdict.
   always @(posedge clock) begin : result_checker
      verdict_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0)
            flag_mismatch($sformatf("result beat with status %0d and no header pending",
                                    rsp_status));
         else begin
            want = pending_verdicts.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_has_v2_part !== want.v2)
               flag_mismatch($sformatf("has_v2_part %b, want %b", rsp_has_v2_part, want.v2));
            if (rsp_has_v3_part !== want.v3)
               flag_mismatch($sformatf("has_v3_part %b, want %b", rsp_has_v3_part, want.v3));
         end
      end
   end

   // Reset values of every register, then a few headers under them: magic 0,
   // oldest version 1, every length 0, every sequence slot at 65535.
   task automatic test_reset_defaults();
      for (csr_idx_type i = REG_MAGIC; i <= REG_LENGTH_V3; i++)
         check_reg(i);
      send_header(pack_header(1'b0, 31, 255, 16'hFFFF, 255, 255, 16'hFFFF, 1'b1));
      send_header(pack_header(1'b1, 0, 0, 0, 0, 0, 7, 1'b1));
      send_header(pack_header(1'b1, 0, 0, 0, 1, 0, 0, 1'b1));
      // A first number of 65535 equals the cleared slot, so it is a replay.
      send_header(pack_header(1'b1, 31, 0, 0, 3, 0, 16'hFFFF, 1'b1));
      send_header(pack_header(1'b1, 1, 0, 0, 255, 255, 1234, 1'b1));
   endtask

   // One header for each rejection of the header checks after the device check,
   // in their order, and the accepted forms of a known and of a newer version.
   task automatic test_header_checks();
      set_config(16'hA55A, 1, 2, 8, 20, 32, 48, 1'b0);
      send_header(pack_header(1'b1, 2, 7, 16'hA55A, 1, 20, 1, 1'b1));
      send_header(pack_header(1'b1, 2, 20, 16'h5AA5, 1, 20, 1, 1'b1));
      send_header(pack_header(1'b1, 2, 8, 16'hA55A, 0, 8, 1, 1'b1));
      send_header(pack_header(1'b1, 2, 31, 16'hA55A, 2, 31, 1, 1'b1));
      send_header(pack_header(1'b1, 2, 30, 16'hA55A, 2, 32, 1, 1'b1));
      // Version 3 lies beyond the newest known one here, so it is checked
      // against the version 2 length, not its own table entry.
      send_header(pack_header(1'b1, 2, 32, 16'hA55A, 3, 31, 1, 1'b1));
      send_header(pack_header(1'b1, 2, 33, 16'hA55A, 3, 40, 1, 1'b1));
      send_header(pack_header(1'b1, 2, 32, 16'hA55A, 3, 40, 1, 1'b1));
      send_header(pack_header(1'b1, 5, 20, 16'hA55A, 1, 20, 9, 1'b1));
      send_header(pack_header(1'b1, 6, 32, 16'hA55A, 2, 32, 9, 1'b0));
   endtask

   // Edges of the replay window, and which verdicts update the store.
   task automatic test_sequence_window();
      send_header(pack_header(1'b1, 3, 20, 16'hA55A, 1, 20, 100, 1'b1));
      send_header(pack_header(1'b1, 3, 20, 16'hA55A, 1, 20, 100, 1'b1));
      send_header(pack_header(1'b1, 3, 20, 16'hA55A, 1, 20, 96, 1'b1));
      send_header(pack_header(1'b1, 3, 20, 16'hA55A, 1, 20, 95, 1'b1));
      // A header that fails only on the managed flag still records its number.
      send_header(pack_header(1'b1, 3, 20, 16'hA55A, 1, 20, 300, 1'b0));
      send_header(pack_header(1'b1, 3, 20, 16'hA55A, 1, 20, 299, 1'b1));
      // A header rejected earlier on leaves the store alone.
      send_header(pack_header(1'b1, 3, 20, 16'h0000, 1, 20, 1000, 1'b1));
      send_header(pack_header(1'b1, 3, 20, 16'hA55A, 1, 20, 296, 1'b1));
      send_header(pack_header(1'b1, 4, 20, 16'hA55A, 1, 20, 65531, 1'b1));
      send_header(pack_header(1'b1, 4, 20, 16'hA55A, 1, 20, 65530, 1'b1));
   endtask

   // Random traffic under the extreme settings of every register.
   task automatic test_extreme_settings();
      set_config(16'hFFFF, 0, 0, 255, 255, 255, 255, 1'b0);
      send_random(40);
      // Only version 255 is new enough here.
      set_config(16'h0000, 255, 3, 0, 0, 0, 0, 1'b0);
      send_random(40);
      set_config(16'hFFFF, 0, 3, 0, 255, 0, 255, 1'b0);
      send_random(40);
   endtask

   // Random traffic under random settings, written with junk in the unused
   // upper bits of each register.
   task automatic test_random_traffic();
      int l0;
      repeat (5) begin
         l0 = $urandom_range(0, 40);
         set_config($urandom,
                    ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 255),
                    $urandom_range(0, 3), l0, $urandom_range(l0, 255),
                    $urandom_range(l0, 255), $urandom_range(l0, 255), 1'b1);
         send_random(56);
      end
   endtask

   initial begin : main_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_header_checks();
      test_sequence_window();
      test_extreme_settings();
      test_random_traffic();
      drain_results();
      // A result beat is offered once its header has moved into the result register;
      // wait on in case a stray beat follows the last expected one.
      repeat (6) @(posedge clock);
      if (pending_verdicts.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
      if (mismatch_count == 0)
         $display("state_packet_acceptance_filter_test OK");
      else
         $display("state_packet_acceptance_filter_test NOT OK");
      $finish;
   end

   // Far beyond the slowest correct run: about 450 headers, each with the
   // longest gap and the longest stall, plus all register accesses.
   initial begin : watchdog
      #400000;
      $display("state_packet_acceptance_filter_test NOT OK");
      $finish;
   end

endmodule
